// File: src/mma_pkg.sv
// Shared types and constants for the magnetometer moving-average block.
package mma_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 20;
    localparam int SAMP_W     = 21;
    localparam int GAIN_W     = 16;
    localparam int GPROD_W    = SAMP_W + GAIN_W + 1;
    localparam int NUM_AXES   = 3;
    localparam int NUM_STAGES = 9;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = CFG_IDX_W'(3);

    localparam logic [RAW_W-1:0]  OFFSET_RESET = RAW_W'(524288);
    localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(4096);

    // Raw bytes of one axis
    typedef struct packed {
        logic [BYTE_W-1:0] high;
        logic [BYTE_W-1:0] mid;
        logic [BYTE_W-1:0] low;
    } mma_axis_t;

    // Pipeline control shared by all lanes
    typedef struct packed {
        logic [NUM_STAGES:1] en;
        logic                accept;
        logic                sample_new;
        logic                ring_full;
        logic                sum_upd;
    } mma_ctrl_t;

endpackage

// File: src/mma_if.sv
// Request channel interfaces: input readings, results and configuration writes.
interface mma_in_if;
    logic       valid;
    logic       ready;
    logic       ready_req;
    logic [7:0] x_high;
    logic [7:0] x_mid;
    logic [7:0] x_low;
    logic [7:0] y_high;
    logic [7:0] y_mid;
    logic [7:0] y_low;
    logic [7:0] z_high;
    logic [7:0] z_mid;
    logic [7:0] z_low;

    modport source (
        output valid, ready_req, x_high, x_mid, x_low, y_high, y_mid, y_low,
               z_high, z_mid, z_low,
        input  ready
    );
    modport sink (
        input  valid, ready_req, x_high, x_mid, x_low, y_high, y_mid, y_low,
               z_high, z_mid, z_low,
        output ready
    );
endinterface

interface mma_out_if;
    logic               valid;
    logic               ready;
    logic signed [20:0] mean_x;
    logic signed [20:0] mean_y;
    logic signed [20:0] mean_z;
    logic signed [20:0] scaled_x;
    logic signed [20:0] scaled_y;
    logic signed [20:0] scaled_z;

    modport source (
        output valid, mean_x, mean_y, mean_z, scaled_x, scaled_y, scaled_z,
        input  ready
    );
    modport sink (
        input  valid, mean_x, mean_y, mean_z, scaled_x, scaled_y, scaled_z,
        output ready
    );
endinterface

interface mma_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [19:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: src/mma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mma_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old contents when both ports hit the same entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/mma_lane.sv
// One axis lane: sample correction, ring, running sum, mean divider and gain.
module mma_lane import mma_pkg::*; #(
    parameter int WINDOW = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  mma_ctrl_t                                ctrl,
    input  mma_axis_t                                axis,
    input  logic [RAW_W-1:0]                         offset,
    input  logic [GAIN_W-1:0]                        gain,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] slot,
    output logic signed [SAMP_W-1:0]                 mean,
    output logic signed [SAMP_W-1:0]                 scaled
);

    localparam int LW     = $clog2(WINDOW);
    localparam int MAG_W  = RAW_W + LW;
    localparam int SUM_W  = MAG_W + 1;
    localparam int Q_W    = SAMP_W;
    localparam logic [MAG_W-1:0] RECIP = MAG_W'((64'd1 << MAG_W) / WINDOW);
    localparam logic [LW:0]      WIN_C = (LW + 1)'(WINDOW);

    // Stage 1: corrected sample, last sample, ring access
    logic signed [SAMP_W-1:0] last_reg;
    logic signed [SAMP_W-1:0] corr;
    logic signed [SAMP_W-1:0] samp_next;
    logic signed [SAMP_W-1:0] samp1_reg;
    logic                     full1_reg;
    logic [RAW_W-1:0]         raw;
    logic [SAMP_W-1:0]        rd_data;

    assign raw       = {axis.high, axis.mid, axis.low[BYTE_W-1 -: 4]};
    assign corr      = $signed({1'b0, raw}) - $signed({1'b0, offset});
    assign samp_next = ctrl.sample_new ? corr : last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (ctrl.accept && ctrl.sample_new)
        begin
            last_reg <= corr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[1])
        begin
            samp1_reg <= samp_next;
            full1_reg <= ctrl.ring_full;
        end
    end

    mma_ram #(
        .WIDTH (SAMP_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .we      (ctrl.accept),
        .wr_addr (slot),
        .wr_data (samp_next),
        .rd_en   (ctrl.accept),
        .rd_addr (slot),
        .rd_data (rd_data)
    );

    // Stage 2: running window sum
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum2_reg;
    logic signed [SAMP_W-1:0] old_samp;

    assign old_samp = full1_reg ? $signed(rd_data) : '0;
    assign sum_next = sum_reg + SUM_W'(samp1_reg) - SUM_W'(old_samp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.sum_upd)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[2])
        begin
            sum2_reg <= sum_next;
        end
    end

    // Stage 3: sign and magnitude
    logic             neg3_reg;
    logic [MAG_W-1:0] mag3_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[3])
        begin
            neg3_reg <= sum2_reg[SUM_W-1];
            mag3_reg <= sum2_reg[SUM_W-1] ? MAG_W'(-sum2_reg) : MAG_W'(sum2_reg);
        end
    end

    // Stage 4: reciprocal multiply
    logic               neg4_reg;
    logic [MAG_W-1:0]   mag4_reg;
    logic [2*MAG_W-1:0] prod4_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[4])
        begin
            neg4_reg  <= neg3_reg;
            mag4_reg  <= mag3_reg;
            prod4_reg <= {{MAG_W{1'b0}}, mag3_reg} * {{MAG_W{1'b0}}, RECIP};
        end
    end

    // Stage 5: quotient estimate and its back product
    logic             neg5_reg;
    logic [MAG_W-1:0] mag5_reg;
    logic [Q_W-1:0]   q0;
    logic [Q_W-1:0]   q0_5_reg;
    logic [MAG_W:0]   qw5_reg;

    assign q0 = prod4_reg[MAG_W +: Q_W];

    always_ff @(posedge clk)
    begin
        if (ctrl.en[5])
        begin
            neg5_reg <= neg4_reg;
            mag5_reg <= mag4_reg;
            q0_5_reg <= q0;
            qw5_reg  <= {{(MAG_W + 1 - Q_W){1'b0}}, q0} *
                        {{(MAG_W - LW){1'b0}}, WIN_C};
        end
    end

    // Stage 6: estimate is low by at most one; fix with remainder check
    logic [MAG_W:0] rem;
    logic           neg6_reg;
    logic [Q_W-1:0] q6_reg;

    assign rem = {1'b0, mag5_reg} - qw5_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[6])
        begin
            neg6_reg <= neg5_reg;
            q6_reg   <= (rem >= {{(MAG_W - LW){1'b0}}, WIN_C}) ? q0_5_reg + Q_W'(1) : q0_5_reg;
        end
    end

    // Stage 7: signed mean, truncated toward zero
    logic signed [SAMP_W-1:0] mean7_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[7])
        begin
            mean7_reg <= neg6_reg ? -$signed(q6_reg) : $signed(q6_reg);
        end
    end

    // Stage 8: gain multiply
    logic signed [SAMP_W-1:0]  mean8_reg;
    logic signed [GPROD_W-1:0] gprod8_reg;
    logic signed [GPROD_W-1:0] gprod_next;

    assign gprod_next = GPROD_W'(mean7_reg) * GPROD_W'($signed({1'b0, gain}));

    always_ff @(posedge clk)
    begin
        if (ctrl.en[8])
        begin
            mean8_reg  <= mean7_reg;
            gprod8_reg <= gprod_next;
        end
    end

    // Arithmetic shift right by sixteen
    assign mean   = mean8_reg;
    assign scaled = gprod8_reg[GAIN_W +: SAMP_W];

endmodule

// File: src/magnetometer_moving_average.sv
// Top level of the three-axis magnetometer moving-average filter.
//
//   channel  | dir | handshake     | payload
//   in_ch    | in  | valid/ready   | ready_req, {x,y,z}_{high,mid,low}
//   out_ch   | out | valid/ready   | mean_{x,y,z}, scaled_{x,y,z}
//   cfg_ch   | in  | valid/ready   | index, data (always ready)
//
// One request per cycle is taken while out_ch does not stall; a result passes through
// the divider and gain pipeline of each axis lane and then the merge register.
// Each axis sum updates as a sample leaves stage 1, so requests follow back to back.
// Reset clears control, sums and the last sample; ring entries not yet written
// read as zero through a ring-full flag, so no clearing pass is needed.
// A stall on out_ch fills the pipeline bubbles first, then drops in_ch.ready.
module magnetometer_moving_average import mma_pkg::*; #(
    parameter int WINDOW = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    mma_in_if.sink    in_ch,
    mma_out_if.source out_ch,
    mma_cfg_if.sink   cfg_ch
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Configuration registers
    logic [RAW_W-1:0]  offset_reg [NUM_AXES];
    logic [GAIN_W-1:0] gain_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg[0] <= OFFSET_RESET;
            offset_reg[1] <= OFFSET_RESET;
            offset_reg[2] <= OFFSET_RESET;
            gain_reg      <= GAIN_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_OFFSET_X: offset_reg[0] <= cfg_ch.data[RAW_W-1:0];
                CFG_OFFSET_Y: offset_reg[1] <= cfg_ch.data[RAW_W-1:0];
                CFG_OFFSET_Z: offset_reg[2] <= cfg_ch.data[RAW_W-1:0];
                CFG_GAIN:     gain_reg      <= cfg_ch.data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Pipeline flow control: a stage loads when empty or when it drains
    logic [NUM_STAGES:1] v_reg;
    logic [NUM_STAGES:1] en;
    logic                accept;

    always_comb
    begin
        en[NUM_STAGES] = !v_reg[NUM_STAGES] || out_ch.ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    assign accept      = in_ch.valid && en[1];
    assign in_ch.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= in_ch.valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k - 1];
                end
            end
        end
    end

    // Ring write pointer and wrap flag
    logic [SLOT_W-1:0] slot_reg;
    logic              full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            full_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (slot_reg == SLOT_W'(WINDOW - 1))
            begin
                slot_reg <= '0;
                full_reg <= 1'b1;
            end
            else
            begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
        end
    end

    // Lane control
    mma_ctrl_t ctrl;

    assign ctrl.en         = en;
    assign ctrl.accept     = accept;
    assign ctrl.sample_new = in_ch.ready_req;
    assign ctrl.ring_full  = full_reg;
    assign ctrl.sum_upd    = v_reg[1] && en[2];

    // Axis lanes
    mma_axis_t                axis_in    [NUM_AXES];
    logic signed [SAMP_W-1:0] lane_mean  [NUM_AXES];
    logic signed [SAMP_W-1:0] lane_scale [NUM_AXES];

    assign axis_in[0] = '{high: in_ch.x_high, mid: in_ch.x_mid, low: in_ch.x_low};
    assign axis_in[1] = '{high: in_ch.y_high, mid: in_ch.y_mid, low: in_ch.y_low};
    assign axis_in[2] = '{high: in_ch.z_high, mid: in_ch.z_mid, low: in_ch.z_low};

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        mma_lane #(
            .WINDOW (WINDOW)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .axis   (axis_in[a]),
            .offset (offset_reg[a]),
            .gain   (gain_reg),
            .slot   (slot_reg),
            .mean   (lane_mean[a]),
            .scaled (lane_scale[a])
        );
    end

    // Merge stage: output register gathering all lanes
    logic signed [SAMP_W-1:0] mean_reg  [NUM_AXES];
    logic signed [SAMP_W-1:0] scale_reg [NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES])
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                mean_reg[a]  <= lane_mean[a];
                scale_reg[a] <= lane_scale[a];
            end
        end
    end

    assign out_ch.valid    = v_reg[NUM_STAGES];
    assign out_ch.mean_x   = mean_reg[0];
    assign out_ch.mean_y   = mean_reg[1];
    assign out_ch.mean_z   = mean_reg[2];
    assign out_ch.scaled_x = scale_reg[0];
    assign out_ch.scaled_y = scale_reg[1];
    assign out_ch.scaled_z = scale_reg[2];

endmodule

// File: src/mma_checker.sv
// Port-level checks on the result channel, bound to the top level.
module mma_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [20:0] mean_x,
    input logic signed [20:0] mean_y,
    input logic signed [20:0] mean_z,
    input logic signed [20:0] scaled_x,
    input logic signed [20:0] scaled_y,
    input logic signed [20:0] scaled_z
);

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its values
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(mean_x) && $stable(mean_y) &&
        $stable(mean_z) && $stable(scaled_x) && $stable(scaled_y) && $stable(scaled_z))
        else $error("result changed while stalled");

    // Gain is non-negative: scaled value never flips the sign of the mean
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mean_x[20] || !scaled_x[20]) && (mean_y[20] || !scaled_y[20]) &&
        (mean_z[20] || !scaled_z[20]))
        else $error("scaled value sign disagrees with mean");

    // Gain is below one: scaled value lies between zero and the mean
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
        (mean_x[20] ? (scaled_x >= mean_x) : (scaled_x <= mean_x)) &&
        (mean_y[20] ? (scaled_y >= mean_y) : (scaled_y <= mean_y)) &&
        (mean_z[20] ? (scaled_z >= mean_z) : (scaled_z <= mean_z)))
        else $error("scaled value exceeds mean magnitude");

endmodule

bind magnetometer_moving_average mma_checker u_mma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .mean_x    (out_ch.mean_x),
    .mean_y    (out_ch.mean_y),
    .mean_z    (out_ch.mean_z),
    .scaled_x  (out_ch.scaled_x),
    .scaled_y  (out_ch.scaled_y),
    .scaled_z  (out_ch.scaled_z)
);

// File: tb/sv/magnetometer_filter_checker.sv
// Checker for the magnetometer moving-average block: predicts each result and compares it.
module magnetometer_filter_checker import mma_pkg::*; #(
    parameter int WINDOW = 16
) (
    input  logic clk,
    input  logic rst_n,
    mma_in_if    in_ch,
    mma_out_if   out_ch,
    mma_cfg_if   cfg_ch,
    output int   errors,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_W = 26;

    // One result as the block should deliver it
    typedef struct packed {
        logic signed [SAMP_W-1:0] mean_x;
        logic signed [SAMP_W-1:0] mean_y;
        logic signed [SAMP_W-1:0] mean_z;
        logic signed [SAMP_W-1:0] scaled_x;
        logic signed [SAMP_W-1:0] scaled_y;
        logic signed [SAMP_W-1:0] scaled_z;
    } axis_means_t;

    // Register copy
    logic [RAW_W-1:0]  zero_offset [NUM_AXES];
    logic [GAIN_W-1:0] gain;

    // Filter state
    logic signed [SAMP_W-1:0] ring      [NUM_AXES][WINDOW];
    logic signed [SAMP_W-1:0] last_corr [NUM_AXES];
    logic signed [SUM_W-1:0]  run_sum   [NUM_AXES];
    int                       slot;

    axis_means_t pending_means [$];
    axis_means_t want;
    int          fail_count = 0;

    assign errors = fail_count;

    function automatic void clear_filter();
        for (int a = 0; a < NUM_AXES; a++)
        begin
            zero_offset[a] = OFFSET_RESET;
            last_corr[a]   = '0;
            run_sum[a]     = '0;
            for (int i = 0; i < WINDOW; i++)
                ring[a][i] = '0;
        end
        gain = GAIN_RESET;
        slot = 0;
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_OFFSET_X: zero_offset[0] = val[RAW_W-1:0];
            CFG_OFFSET_Y: zero_offset[1] = val[RAW_W-1:0];
            CFG_OFFSET_Z: zero_offset[2] = val[RAW_W-1:0];
            CFG_GAIN:     gain = val[GAIN_W-1:0];
            default:      ;  // unmapped index, no effect
        endcase
    endfunction

    // Push one reading through the rings and return the window means and scaled values
    function automatic axis_means_t average_reading(logic take_new, mma_axis_t ax,
                                                    mma_axis_t ay, mma_axis_t az);
        mma_axis_t                axes   [NUM_AXES];
        logic signed [SAMP_W-1:0] mean   [NUM_AXES];
        logic signed [SAMP_W-1:0] scaled [NUM_AXES];
        logic signed [GPROD_W-1:0] prod;
        axis_means_t              r;
        axes[0] = ax;
        axes[1] = ay;
        axes[2] = az;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            // raw = high<<12 | mid<<4 | low>>4, minus the axis offset
            if (take_new)
                last_corr[a] = $signed({1'b0, axes[a].high, axes[a].mid, axes[a].low[7:4]})
                             - $signed({1'b0, zero_offset[a]});
            run_sum[a]     = run_sum[a] + SUM_W'(last_corr[a]) - SUM_W'(ring[a][slot]);
            ring[a][slot]  = last_corr[a];
            mean[a]        = SAMP_W'(run_sum[a] / WINDOW);      // truncates toward zero
            prod           = GPROD_W'(mean[a]) * GPROD_W'($signed({1'b0, gain}));
            scaled[a]      = SAMP_W'(prod >>> 16);              // floors
        end
        slot = (slot + 1 == WINDOW) ? 0 : slot + 1;
        r.mean_x   = mean[0];
        r.mean_y   = mean[1];
        r.mean_z   = mean[2];
        r.scaled_x = scaled[0];
        r.scaled_y = scaled[1];
        r.scaled_z = scaled[2];
        return r;
    endfunction

    function automatic void check_field(string name, logic signed [SAMP_W-1:0] exp_val,
                                        logic signed [SAMP_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_filter();
            pending_means.delete();
        end
        else
        begin
            // results leaving the block
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_means.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, expected none actual %0d",
                             $time, out_ch.mean_x);
                    fail_count++;
                end
                else
                begin
                    want = pending_means.pop_front();
                    check_field("mean_x",   want.mean_x,   out_ch.mean_x);
                    check_field("mean_y",   want.mean_y,   out_ch.mean_y);
                    check_field("mean_z",   want.mean_z,   out_ch.mean_z);
                    check_field("scaled_x", want.scaled_x, out_ch.scaled_x);
                    check_field("scaled_y", want.scaled_y, out_ch.scaled_y);
                    check_field("scaled_z", want.scaled_z, out_ch.scaled_z);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                apply_write(cfg_ch.index, cfg_ch.data);
            // requests entering the block
            if (in_ch.valid && in_ch.ready)
                pending_means.push_back(average_reading(in_ch.ready_req,
                    {in_ch.x_high, in_ch.x_mid, in_ch.x_low},
                    {in_ch.y_high, in_ch.y_mid, in_ch.y_low},
                    {in_ch.z_high, in_ch.z_mid, in_ch.z_low}));
        end
        outstanding <= pending_means.size();
    end

endmodule

// File: tb/sv/tb_magnetometer_moving_average.sv
// Top of the magnetometer moving-average testbench: clock, reset, stimulus and verdict.
module tb_magnetometer_moving_average import mma_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_GAIN + CFG_IDX_W'(1);
    localparam logic [RAW_W-1:0]     OFFSET_MAX = '1;

    typedef enum {SPREAD_FULL, SPREAD_HIGH, SPREAD_LOW} spread_t;

    typedef struct packed {
        logic      ready_req;
        mma_axis_t x;
        mma_axis_t y;
        mma_axis_t z;
    } reading_t;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   outstanding;

    mma_in_if  in_ch ();
    mma_out_if out_ch ();
    mma_cfg_if cfg_ch ();

    magnetometer_moving_average #(.WINDOW(WINDOW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    magnetometer_filter_checker #(.WINDOW(WINDOW)) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_ch      (cfg_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: changing stall pattern plus one long hold-off
    initial
    begin : result_sink
        int  cyc = 0;
        int  taken = 0;
        int  hold = 0;
        bit  held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                taken++;
            if (!held && taken >= 60)
            begin
                held = 1'b1;
                hold = 400;
            end
            if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case ((cyc / 97) % 4)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    2:       out_ch.ready <= (cyc % 4 == 0);
                    default: out_ch.ready <= ($urandom_range(0, 9) < 8);
                endcase
            end
            cyc++;
        end
    end

    function automatic logic [7:0] pick_byte(spread_t sp);
        case (sp)
            SPREAD_HIGH: return ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom);
            SPREAD_LOW:  return ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom);
            default:     return 8'($urandom);
        endcase
    endfunction

    function automatic reading_t make_reading(spread_t sp, int ready_pct);
        reading_t r;
        r.ready_req = ($urandom_range(0, 99) < ready_pct);
        r.x = {pick_byte(sp), pick_byte(sp), pick_byte(sp)};
        r.y = {pick_byte(sp), pick_byte(sp), pick_byte(sp)};
        r.z = {pick_byte(sp), pick_byte(sp), pick_byte(sp)};
        return r;
    endfunction

    // Offer one request and hold it until taken
    task automatic send_reading(input reading_t r);
        in_ch.valid     <= 1'b1;
        in_ch.ready_req <= r.ready_req;
        in_ch.x_high    <= r.x.high;
        in_ch.x_mid     <= r.x.mid;
        in_ch.x_low     <= r.x.low;
        in_ch.y_high    <= r.y.high;
        in_ch.y_mid     <= r.y.mid;
        in_ch.y_low     <= r.y.low;
        in_ch.z_high    <= r.z.high;
        in_ch.z_mid     <= r.z.mid;
        in_ch.z_low     <= r.z.low;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // All four registers, then a write to an unmapped index that must change nothing
    task automatic program_filter(input logic [RAW_W-1:0] ox, input logic [RAW_W-1:0] oy,
                                  input logic [RAW_W-1:0] oz,
                                  input logic [CFG_DATA_W-1:0] gain_word);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_OFFSET_Z, oz);
        write_reg(CFG_GAIN, gain_word);
        write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, 255)), CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Bursts of random length separated by random gaps
    task automatic run_random(input int n, input spread_t sp, input int ready_pct,
                              input int max_gap);
        int sent = 0;
        int burst;
        while (sent < n)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < n; i++)
            begin
                send_reading(make_reading(sp, ready_pct));
                sent++;
            end
            idle_gap($urandom_range(0, max_gap));
        end
    endtask

    initial
    begin : stimulus
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.ready_req <= 1'b0;
        in_ch.x_high    <= '0;
        in_ch.x_mid     <= '0;
        in_ch.x_low     <= '0;
        in_ch.y_high    <= '0;
        in_ch.y_mid     <= '0;
        in_ch.y_low     <= '0;
        in_ch.z_high    <= '0;
        in_ch.z_mid     <= '0;
        in_ch.z_low     <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: reuse before any reading, raw extremes, ignored low nibble
        send_reading({1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
        send_reading({1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
        idle_gap(2);
        send_reading({1'b1, 24'h000000, 24'h000000, 24'h000000});
        send_reading({1'b0, 24'h123456, 24'hABCDEF, 24'h5A5A5A});
        send_reading({1'b1, 24'h800000, 24'h800000, 24'h800000});
        idle_gap(1);
        send_reading({1'b1, 24'h80000F, 24'h7FFFF0, 24'h80001F});
        send_reading({1'b1, 24'hFFFFFF, 24'h000000, 24'h8000F0});
        send_reading({1'b0, 24'h000000, 24'hFFFFFF, 24'h0F0F0F});
        wait_idle();

        // Largest corrections both ways with full gain; gain upper data bits are dropped
        program_filter('0, OFFSET_MAX, '0, 20'hFFFFF);
        send_reading({1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'h000000});
        send_reading({1'b1, 24'h000000, 24'h000000, 24'hFFFFFF});
        send_reading({1'b0, 24'h000000, 24'h000000, 24'h000000});
        send_reading({1'b1, 24'hFFFFFF, 24'h000000, 24'hFFFFFF});
        wait_idle();

        // Unit gain on small negative means shows the floor of the shift
        program_filter(OFFSET_RESET, OFFSET_RESET, OFFSET_RESET, 20'h00001);
        send_reading({1'b1, 24'h7FFFF0, 24'h7FFF00, 24'h000000});
        send_reading({1'b1, 24'h7FFFF0, 24'h800010, 24'h7FFFF0});
        send_reading({1'b1, 24'h800000, 24'h7FFFF0, 24'h800000});
        wait_idle();

        // Random phases over several register settings
        program_filter(OFFSET_RESET, OFFSET_RESET, OFFSET_RESET, {4'h0, GAIN_RESET});
        run_random(200, SPREAD_FULL, 85, 6);
        wait_idle();

        program_filter('0, '0, '0, {4'($urandom), 16'hFFFF});
        run_random(150, SPREAD_HIGH, 90, 5);
        wait_idle();

        program_filter(OFFSET_MAX, OFFSET_MAX, OFFSET_MAX, {4'($urandom), 16'hFFFF});
        run_random(150, SPREAD_LOW, 90, 5);
        wait_idle();

        program_filter(RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                       {4'($urandom), 16'h0000});
        run_random(150, SPREAD_FULL, 80, 0);
        wait_idle();

        program_filter(RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                       CFG_DATA_W'($urandom));
        run_random(150, SPREAD_FULL, 75, 8);
        wait_idle();

        program_filter(OFFSET_RESET, RAW_W'($urandom), OFFSET_RESET,
                       {4'hA, 16'($urandom)});
        run_random(100, SPREAD_FULL, 30, 4);
        wait_idle();

        repeat (20) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: magnetometer_moving_average.f
src/mma_pkg.sv
src/mma_if.sv
src/mma_ram.sv
src/mma_lane.sv
src/magnetometer_moving_average.sv
src/mma_checker.sv
tb/sv/magnetometer_filter_checker.sv
tb/sv/tb_magnetometer_moving_average.sv
